@@ design/sspq_pkg.sv @@
// ----------------------------------------------------------------------------
// sspq_pkg
// Shared types and codes for the stable sorted priority queue.
// ----------------------------------------------------------------------------
package sspq_pkg;

    localparam int PRIO_W = 16;
    localparam int TAG_W  = 16;

    // operation codes on the input channel
    localparam logic [1:0] FUNC_PUSH = 2'd0;
    localparam logic [1:0] FUNC_POP  = 2'd1;
    localparam logic [1:0] FUNC_PEEK = 2'd2;

    // result status codes
    localparam logic [1:0] STATUS_OK         = 2'd0;
    localparam logic [1:0] STATUS_POP_EMPTY  = 2'd1;
    localparam logic [1:0] STATUS_PUSH_FULL  = 2'd2;

    // one stored entry
    typedef struct packed {
        logic                     used;
        logic signed [PRIO_W-1:0] prio;
        logic        [TAG_W-1:0]  tag;
    } t_entry;

    // operation broadcast to every cell
    typedef struct packed {
        logic                     push_en;
        logic                     pop_en;
        logic signed [PRIO_W-1:0] prio;
        logic        [TAG_W-1:0]  tag;
    } t_ctrl;

endpackage

@@ design/sspq_cell.sv @@
// ----------------------------------------------------------------------------
// sspq_cell
// One slot of the sorted chain: holds an entry, shifts right on an insert
// ahead of it and left on a pop.
// ----------------------------------------------------------------------------
module sspq_cell (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  sspq_pkg::t_ctrl i_ctrl,
    input  sspq_pkg::t_entry i_left,
    input  logic            i_left_ins,
    input  sspq_pkg::t_entry i_right,
    output sspq_pkg::t_entry o_entry,
    output sspq_pkg::t_entry o_next,
    output logic            o_ins
);
    import sspq_pkg::*;

    logic                     r_used;
    logic signed [PRIO_W-1:0] r_prio;
    logic        [TAG_W-1:0]  r_tag;
    t_entry                   n_entry;

    // insertion point lies at or before this slot
    assign o_ins = !r_used || (r_prio > i_ctrl.prio);

    always_comb begin
        n_entry.used = r_used;
        n_entry.prio = r_prio;
        n_entry.tag  = r_tag;
        if (i_ctrl.push_en) begin
            n_entry.used = r_used | i_left.used;
            if (o_ins) begin
                if (i_left_ins) begin
                    n_entry.prio = i_left.prio;
                    n_entry.tag  = i_left.tag;
                end else begin
                    n_entry.prio = i_ctrl.prio;
                    n_entry.tag  = i_ctrl.tag;
                end
            end
        end else if (i_ctrl.pop_en) begin
            n_entry = i_right;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= 1'b0;
        end else begin
            r_used <= n_entry.used;
        end
        r_prio <= n_entry.prio;
        r_tag  <= n_entry.tag;
    end

    assign o_entry = '{used: r_used, prio: r_prio, tag: r_tag};
    assign o_next  = n_entry;

endmodule

@@ design/stable_sorted_priority_queue.sv @@
// ----------------------------------------------------------------------------
// stable_sorted_priority_queue
// Min-first priority queue of DEPTH entries kept sorted in a chain of cells.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries one operation per
//   transfer: push (i_prio, i_tag), pop of the head, or peek. An unknown
//   func code acts as a peek.
//   Output channel (o_out_valid / i_out_stall) returns exactly one result
//   per operation: head priority and tag after the operation (zero when
//   empty), empty and full flags, and a status code. A pop on an empty
//   queue and a push into a full queue change nothing and are flagged.
//   The result is registered and valid in the cycle after the input transfer.
//   Throughput is one operation per cycle unless the output stalls: every
//   cell compares its stored priority with the broadcast one in the same
//   cycle and takes its neighbor's entry, so one cell update sets the rate.
//   When the receiver stalls, the single result register holds and the
//   input stalls until it drains; no result is lost.
//   Reset (synchronous, active low) empties the queue at once; the stored
//   priorities and tags are left as they are and are never shown.
// ----------------------------------------------------------------------------
module stable_sorted_priority_queue #(
    parameter int DEPTH = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [1:0]                        i_func,
    input  logic signed [sspq_pkg::PRIO_W-1:0] i_prio,
    input  logic [sspq_pkg::TAG_W-1:0]        i_tag,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic signed [sspq_pkg::PRIO_W-1:0] o_head_prio,
    output logic [sspq_pkg::TAG_W-1:0]        o_head_tag,
    output logic                              o_is_empty,
    output logic                              o_is_full,
    output logic [1:0]                        o_status
);
    import sspq_pkg::*;

    t_entry     w_entry [DEPTH];
    t_entry     w_next  [DEPTH];
    logic       w_ins   [DEPTH];
    logic [DEPTH-1:0] w_used;
    t_ctrl      w_ctrl;
    logic       w_accept;
    logic       w_empty;
    logic       w_full;
    logic [1:0] w_status;

    logic                     r_out_valid;
    logic signed [PRIO_W-1:0] r_head_prio;
    logic        [TAG_W-1:0]  r_head_tag;
    logic                     r_is_empty;
    logic                     r_is_full;
    logic [1:0]               r_status;

    // a finished result that cannot leave blocks the next transfer
    assign o_in_stall = r_out_valid && i_out_stall;
    assign w_accept   = i_in_valid && !o_in_stall;

    // queue state before the operation; used slots always form a prefix
    assign w_empty = !w_entry[0].used;
    assign w_full  = w_entry[DEPTH-1].used;

    always_comb begin
        w_ctrl.push_en = w_accept && (i_func == FUNC_PUSH) && !w_full;
        w_ctrl.pop_en  = w_accept && (i_func == FUNC_POP) && !w_empty;
        w_ctrl.prio    = i_prio;
        w_ctrl.tag     = i_tag;
        if (i_func == FUNC_PUSH && w_full) begin
            w_status = STATUS_PUSH_FULL;
        end else if (i_func == FUNC_POP && w_empty) begin
            w_status = STATUS_POP_EMPTY;
        end else begin
            w_status = STATUS_OK;
        end
    end

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++) begin : g_cell
            t_entry w_left;
            t_entry w_right;
            logic   w_left_ins;

            if (g == 0) begin : g_first
                // virtual full slot ahead of the head, never past the insert
                assign w_left     = '{used: 1'b1, prio: '0, tag: '0};
                assign w_left_ins = 1'b0;
            end else begin : g_mid
                assign w_left     = w_entry[g-1];
                assign w_left_ins = w_ins[g-1];
            end

            if (g == DEPTH-1) begin : g_last
                assign w_right = '{used: 1'b0, prio: '0, tag: '0};
            end else begin : g_inner
                assign w_right = w_entry[g+1];
            end

            sspq_cell u_cell (
                .i_clk      (i_clk),
                .i_rst_n    (i_rst_n),
                .i_ctrl     (w_ctrl),
                .i_left     (w_left),
                .i_left_ins (w_left_ins),
                .i_right    (w_right),
                .o_entry    (w_entry[g]),
                .o_next     (w_next[g]),
                .o_ins      (w_ins[g])
            );

            assign w_used[g] = w_entry[g].used;
        end
    endgenerate

    // result register: head after the operation comes from the cells' next value
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
        if (w_accept) begin
            r_head_prio <= w_next[0].used ? w_next[0].prio : '0;
            r_head_tag  <= w_next[0].used ? w_next[0].tag  : '0;
            r_is_empty  <= !w_next[0].used;
            r_is_full   <= w_next[DEPTH-1].used;
            r_status    <= w_status;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_head_prio = r_head_prio;
    assign o_head_tag  = r_head_tag;
    assign o_is_empty  = r_is_empty;
    assign o_is_full   = r_is_full;
    assign o_status    = r_status;

    // used slots stay a contiguous prefix
    a_used_prefix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((w_used >> 1) & ~w_used) == '0)
        else $error("used slots not a prefix");

    // the two head slots stay in priority order
    a_head_sorted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_entry[1].used |-> (w_entry[0].prio <= w_entry[1].prio))
        else $error("head slots out of order");

    // a push that fits leaves a non-empty queue and reports ok
    a_push_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_func == FUNC_PUSH && !w_full)
        |=> (o_out_valid && !o_is_empty && o_status == STATUS_OK))
        else $error("push result wrong");

    // a pop on an empty queue is flagged and leaves it empty
    a_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_func == FUNC_POP && w_empty)
        |=> (o_out_valid && o_is_empty && o_status == STATUS_POP_EMPTY))
        else $error("pop on empty result wrong");

    // full and empty never show together
    a_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_is_full && o_is_empty))
        else $error("full and empty both set");

endmodule

@@ tb/tb_stable_sorted_priority_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_stable_sorted_priority_queue
// Self-checking bench for the stable min-first priority queue. A behavioral
// queue model predicts head, flags and status for every accepted operation;
// each returned result is checked against the oldest prediction. Directed
// runs cover the empty and full corners, extreme priorities and ties;
// random runs swing the fill level between empty and full under bursty
// sending and a patterned output stall.
// ----------------------------------------------------------------------------
module tb_stable_sorted_priority_queue;

    import sspq_pkg::*;

    localparam int QDEPTH = 16;
    // func code with no defined meaning; the block treats it as a peek
    localparam logic [1:0] FUNC_RSVD = 2'd3;

    // one stored entry of the model queue
    typedef struct {
        logic signed [PRIO_W-1:0] prio;
        logic        [TAG_W-1:0]  tag;
    } t_slot;

    // what one operation returns
    typedef struct {
        logic signed [PRIO_W-1:0] head_prio;
        logic        [TAG_W-1:0]  head_tag;
        logic                     is_empty;
        logic                     is_full;
        logic [1:0]               status;
    } t_head_report;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n;
    logic                     i_in_valid;
    logic                     o_in_stall;
    logic [1:0]               i_func;
    logic signed [PRIO_W-1:0] i_prio;
    logic [TAG_W-1:0]         i_tag;
    logic                     o_out_valid;
    logic                     i_out_stall;
    logic signed [PRIO_W-1:0] o_head_prio;
    logic [TAG_W-1:0]         o_head_tag;
    logic                     o_is_empty;
    logic                     o_is_full;
    logic [1:0]               o_status;

    // model contents, slot 0 is the head
    t_slot        model_slots[$];
    // predicted reports waiting for their result transfer
    t_head_report pending_heads[$];

    int fail_count  = 0;
    int burst_left  = 0;
    bit sender_gaps = 1'b1;
    int rx_hold_left = 0;

    stable_sorted_priority_queue #(
        .DEPTH(QDEPTH)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_func      (i_func),
        .i_prio      (i_prio),
        .i_tag       (i_tag),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_head_prio (o_head_prio),
        .o_head_tag  (o_head_tag),
        .o_is_empty  (o_is_empty),
        .o_is_full   (o_is_full),
        .o_status    (o_status)
    );

    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Queue model: applies one operation and returns the report.
    // A push goes behind every entry with equal or lower priority, which
    // keeps equal priorities in arrival order.
    // ------------------------------------------------------------------
    function automatic t_head_report apply_queue_op(logic [1:0] func,
                                                    logic signed [PRIO_W-1:0] prio,
                                                    logic [TAG_W-1:0] tag);
        t_head_report rep;
        t_slot        ent;
        int           pos;
        rep.status = STATUS_OK;
        case (func)
            FUNC_PUSH: begin
                if (model_slots.size() >= QDEPTH) begin
                    rep.status = STATUS_PUSH_FULL;
                end else begin
                    pos = 0;
                    while (pos < model_slots.size() && model_slots[pos].prio <= prio)
                        pos++;
                    ent.prio = prio;
                    ent.tag  = tag;
                    model_slots.insert(pos, ent);
                end
            end
            FUNC_POP: begin
                if (model_slots.size() == 0)
                    rep.status = STATUS_POP_EMPTY;
                else
                    void'(model_slots.pop_front());
            end
            default: ;  // peek and the reserved code change nothing
        endcase
        if (model_slots.size() > 0) begin
            rep.head_prio = model_slots[0].prio;
            rep.head_tag  = model_slots[0].tag;
        end else begin
            rep.head_prio = '0;
            rep.head_tag  = '0;
        end
        rep.is_empty = (model_slots.size() == 0);
        rep.is_full  = (model_slots.size() == QDEPTH);
        return rep;
    endfunction

    task automatic log_failure(input string msg);
        fail_count++;
        if (fail_count <= 10)
            $display("[%0t] %s", $realtime, msg);
    endtask

    // ------------------------------------------------------------------
    // Transfer monitor. Sampled right after the edge, so all values seen
    // are the ones the block saw at that edge. The result side is checked
    // first; an operation accepted at this edge cannot have its result
    // before the next one.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : transfer_monitor
        t_head_report want;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (pending_heads.size() == 0) begin
                    log_failure($sformatf("result with nothing pending: prio %0d tag %h",
                                          o_head_prio, o_head_tag));
                end else begin
                    want = pending_heads.pop_front();
                    if (o_head_prio !== want.head_prio || o_head_tag !== want.head_tag ||
                        o_is_empty !== want.is_empty || o_is_full !== want.is_full ||
                        o_status !== want.status) begin
                        log_failure($sformatf({"mismatch: exp prio %0d tag %h empty %b ",
                            "full %b status %0d, got prio %0d tag %h empty %b full %b ",
                            "status %0d"},
                            want.head_prio, want.head_tag, want.is_empty, want.is_full,
                            want.status, o_head_prio, o_head_tag, o_is_empty, o_is_full,
                            o_status));
                    end
                end
            end
            if (i_in_valid && !o_in_stall)
                pending_heads.push_back(apply_queue_op(i_func, i_prio, i_tag));
        end
    end

    // ------------------------------------------------------------------
    // Receiver stall pattern: runs of no stall, random stall and a
    // periodic stall, each of random length. A hold-off request from a
    // test overrides the pattern for a counted number of cycles.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : rx_stall_pattern
        int rx_mode;
        int rx_run;
        int rx_phase;
        if (rx_hold_left > 0) begin
            i_out_stall <= 1'b1;
            rx_hold_left--;
        end else begin
            if (rx_run <= 0) begin
                rx_mode = $urandom_range(0, 2);
                rx_run  = $urandom_range(4, 40);
            end
            rx_run--;
            rx_phase++;
            case (rx_mode)
                0:       i_out_stall <= 1'b0;
                1:       i_out_stall <= ($urandom_range(0, 99) < 35);
                default: i_out_stall <= (rx_phase % 3 == 0);
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Send one operation. Must be entered right after a rising edge and
    // returns at the edge where the transfer happened. Valid stays high
    // into the next call unless a gap between bursts starts.
    // ------------------------------------------------------------------
    task automatic send_op(input logic [1:0] func,
                           input logic signed [PRIO_W-1:0] prio,
                           input logic [TAG_W-1:0] tag);
        int gap;
        if (sender_gaps) begin
            if (burst_left == 0) begin
                gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                if (gap > 0) begin
                    i_in_valid <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
                burst_left = $urandom_range(1, 16);
            end
            burst_left--;
        end
        i_in_valid <= 1'b1;
        i_func     <= func;
        i_prio     <= prio;
        i_tag      <= tag;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    // Stop sending until every predicted result has come back.
    task automatic wait_for_drain();
        i_in_valid <= 1'b0;
        // one edge first so the last transfer's prediction is queued
        do @(posedge i_clk); while (pending_heads.size() != 0);
    endtask

    // empty queue: peek, pop on empty, reserved code
    task automatic test_empty_queue();
        send_op(FUNC_PEEK, 16'sd0, 16'h0000);
        send_op(FUNC_POP,  16'sd0, 16'hFFFF);
        send_op(FUNC_RSVD, -16'sd1, 16'hFFFF);
        send_op(FUNC_POP,  16'sh7FFF, 16'h1234);
    endtask

    // fill to full with extremes and ties, then push on full and unwind a bit
    task automatic test_fill_to_full();
        logic signed [PRIO_W-1:0] fill_prio[16] = '{
            16'sh7FFF, 16'sh8000, 16'sd0, 16'sd0, -16'sd1, 16'sd1, 16'sd0, 16'sh8000,
            16'sh7FFF, 16'sd100, -16'sd100, 16'sd5, 16'sd5, -16'sd7, 16'sd12, 16'sh4000};
        logic [TAG_W-1:0] fill_tag[16] = '{
            16'hFFFF, 16'h0000, 16'h0001, 16'h0002, 16'h8001, 16'h0003, 16'h0004, 16'hAAAA,
            16'h5555, 16'h0100, 16'h0200, 16'h0301, 16'h0302, 16'h0400, 16'h0500, 16'h7FFF};
        foreach (fill_prio[k])
            send_op(FUNC_PUSH, fill_prio[k], fill_tag[k]);
        // a priority as low as the lowest held one must still be dropped
        send_op(FUNC_PUSH, 16'sh8000, 16'hBEEF);
        send_op(FUNC_RSVD, 16'sd0, 16'h0000);
        send_op(FUNC_POP,  16'sd0, 16'h0000);
        send_op(FUNC_POP,  16'sd0, 16'h0000);
    endtask

    // random operations in rounds that pull the fill level up or down
    task automatic test_random_ops(input int rounds, input int per_round);
        int push_pct;
        bit narrow;
        int r;
        logic [1:0] func;
        logic signed [PRIO_W-1:0] prio;
        for (int rnd = 0; rnd < rounds; rnd++) begin
            push_pct = $urandom_range(10, 90);
            narrow   = 1'($urandom_range(0, 1));
            for (int n = 0; n < per_round; n++) begin
                r = $urandom_range(0, 99);
                if (r < push_pct)
                    func = FUNC_PUSH;
                else if (r < push_pct + (100 - push_pct) * 3 / 4)
                    func = FUNC_POP;
                else if ($urandom_range(0, 3) == 0)
                    func = FUNC_RSVD;
                else
                    func = FUNC_PEEK;
                // narrow priorities force many ties and stable ordering
                if (narrow)
                    prio = PRIO_W'($urandom_range(0, 6) - 3);
                else
                    prio = PRIO_W'($urandom);
                send_op(func, prio, TAG_W'($urandom));
            end
            if ($urandom_range(0, 1) == 0)
                wait_for_drain();
        end
    endtask

    // receiver holds off while the sender keeps offering back to back
    task automatic test_output_holdoff();
        sender_gaps = 1'b0;
        rx_hold_left = 60;
        for (int n = 0; n < 24; n++)
            send_op(($urandom_range(0, 2) == 0) ? FUNC_POP : FUNC_PUSH,
                    PRIO_W'($urandom), TAG_W'($urandom));
        sender_gaps = 1'b1;
        wait_for_drain();
    endtask

    initial begin
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_func      = FUNC_PEEK;
        i_prio      = '0;
        i_tag       = '0;
        i_out_stall = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_queue();
        test_fill_to_full();
        test_output_holdoff();
        test_random_ops(6, 90);
        test_output_holdoff();

        wait_for_drain();
        // any late or extra result would show up in this window
        repeat (10) @(posedge i_clk);
        if (fail_count == 0 && pending_heads.size() == 0) begin
            $display("stable_sorted_priority_queue test passed");
        end else begin
            $display("stable_sorted_priority_queue test failed");
        end
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial begin
        #2_000_000;
        $display("stable_sorted_priority_queue test failed");
        $finish;
    end

endmodule

@@ stable_sorted_priority_queue.f @@
design/sspq_pkg.sv
design/sspq_cell.sv
design/stable_sorted_priority_queue.sv
tb/tb_stable_sorted_priority_queue.sv
